// ===== src/dle_pkg.sv =====
// Shared types, codes and constants of the direct link establishment block.
package dle_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SELF_L2_ID    = 3'd0,
    CFG_PEER_L2_ID    = 3'd1,
    CFG_IS_INITIATING = 3'd2,
    CFG_IS_RELAY_CONN = 3'd3,
    CFG_RELAY_CODE    = 3'd4,
    CFG_SELF_IP       = 3'd5,
    CFG_RTX_MAX       = 3'd6,
    CFG_RETX_TICKS    = 3'd7
  } cfg_idx_t;

  // Input event kinds.
  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_RX_REQ = 3'd1,
    KIND_RX_ACC = 3'd2,
    KIND_RX_REJ = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  // Link states as reported in notices.
  typedef enum logic [2:0] {
    LS_INIT         = 3'd0,
    LS_ESTABLISHING = 3'd1,
    LS_ESTABLISHED  = 3'd2,
    LS_RELEASING    = 3'd3,
    LS_RELEASED     = 3'd4
  } link_state_t;

  // Record sequences handed from the front end to the back end.
  typedef enum logic [2:0] {
    ACT_START      = 3'd0,
    ACT_REQ_ACCEPT = 3'd1,
    ACT_REQ_REJECT = 3'd2,
    ACT_RESEND_ACC = 3'd3,
    ACT_ACC_OK     = 3'd4,
    ACT_REJ_OK     = 3'd5,
    ACT_RETX       = 3'd6,
    ACT_ERROR      = 3'd7
  } action_t;

  // Record kinds, message types, logical channels and relay roles.
  localparam logic [1:0] REC_SEND    = 2'd0;
  localparam logic [1:0] REC_NOTICE  = 2'd1;
  localparam logic [1:0] REC_ERROR   = 2'd2;
  localparam logic [1:0] MSG_REQ     = 2'd0;
  localparam logic [1:0] MSG_ACC     = 2'd1;
  localparam logic [1:0] MSG_REJ     = 2'd2;
  localparam logic [1:0] LC_REQ      = 2'd0;
  localparam logic [1:0] LC_RSP      = 2'd2;
  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_REMOTE = 2'd1;
  localparam logic [1:0] ROLE_RELAY  = 2'd2;

  // Cause values.
  localparam logic [7:0] CAUSE_NONE       = 8'd0;
  localparam logic [7:0] CAUSE_RELAY_FAIL = 8'd1;
  localparam logic [7:0] CAUSE_STD_LOW    = 8'd1;
  localparam logic [7:0] CAUSE_STD_HIGH   = 8'd12;
  localparam logic [7:0] CAUSE_PROTOCOL   = 8'd111;

  // Register reset values.
  localparam logic [7:0]  RTX_MAX_RST    = 8'd3;
  localparam logic [31:0] RETX_TICKS_RST = 32'd8000;

  // Queue between front end and back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [23:0] self_l2_id;
    logic [23:0] peer_l2_id;
    logic        is_initiating;
    logic        is_relay_conn;
    logic [23:0] relay_code;
    logic [31:0] self_ip;
    logic [7:0]  rtx_max;
    logic [31:0] retx_ticks;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    link_state_t state;
    logic [31:0] peer_ip;
  } qentry_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [1:0]  msg_type;
    logic [23:0] dest_l2_id;
    logic [1:0]  lc_id;
    logic [23:0] src_l2_id;
    logic [23:0] relay_code_out;
    logic [7:0]  reject_cause;
    logic [31:0] ip_tag;
    logic [2:0]  link_state;
    logic [31:0] peer_ip_out;
    logic [1:0]  relay_role;
    logic        last;
  } rec_t;

endpackage

// ===== src/dle_front.sv =====
// Front end: accepts events, keeps link state and timer, queues record sequences.
module dle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  dle_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_kind,
  input  logic [23:0]         in_rx_relay_code,
  input  logic [31:0]         in_rx_peer_ip,
  input  logic [7:0]          in_rx_cause,
  input  logic                q_full,
  output logic                q_push,
  output dle_pkg::qentry_t    q_data
);

  dle_pkg::link_state_t state_r, state_nxt;
  logic [31:0] timer_count_r, timer_count_nxt;
  logic        timer_running_r, timer_running_nxt;
  logic [7:0]  retry_count_r, retry_count_nxt;
  logic [31:0] peer_ip_r, peer_ip_nxt;
  logic        accept;
  logic        req_ok;
  logic        cause_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Relay check on a received request and validity of a received reject cause.
  always_comb begin
    req_ok = 1'b1;
    if (cfg.is_relay_conn && (in_rx_relay_code != 24'd0)) begin
      req_ok = !cfg.is_initiating && (in_rx_relay_code == cfg.relay_code);
    end
    cause_ok = ((in_rx_cause >= dle_pkg::CAUSE_STD_LOW) &&
                (in_rx_cause <= dle_pkg::CAUSE_STD_HIGH)) ||
               (in_rx_cause == dle_pkg::CAUSE_PROTOCOL);
  end

  // Event classification and state update.
  always_comb begin
    state_nxt         = state_r;
    timer_count_nxt   = timer_count_r;
    timer_running_nxt = timer_running_r;
    retry_count_nxt   = retry_count_r;
    peer_ip_nxt       = peer_ip_r;
    q_push            = 1'b0;
    q_data.action     = dle_pkg::ACT_ERROR;
    q_data.state      = state_r;
    q_data.peer_ip    = peer_ip_r;
    if (accept) begin
      unique case (dle_pkg::kind_t'(in_kind))
        dle_pkg::KIND_START: begin
          q_push = 1'b1;
          if (state_r == dle_pkg::LS_INIT) begin
            q_data.action     = dle_pkg::ACT_START;
            timer_count_nxt   = cfg.retx_ticks;
            timer_running_nxt = 1'b1;
            state_nxt         = dle_pkg::LS_ESTABLISHING;
          end else begin
            q_data.action = dle_pkg::ACT_ERROR;
          end
        end
        dle_pkg::KIND_RX_REQ: begin
          priority if (state_r == dle_pkg::LS_INIT) begin
            q_push = 1'b1;
            if (req_ok) begin
              q_data.action  = dle_pkg::ACT_REQ_ACCEPT;
              q_data.peer_ip = in_rx_peer_ip;
              peer_ip_nxt    = in_rx_peer_ip;
              state_nxt      = dle_pkg::LS_ESTABLISHED;
            end else begin
              q_data.action = dle_pkg::ACT_REQ_REJECT;
              state_nxt     = dle_pkg::LS_RELEASED;
            end
          end else if (state_r == dle_pkg::LS_ESTABLISHING) begin
            q_push        = 1'b1;
            q_data.action = dle_pkg::ACT_ERROR;
          end else if (state_r == dle_pkg::LS_ESTABLISHED) begin
            q_push        = 1'b1;
            q_data.action = dle_pkg::ACT_RESEND_ACC;
          end else begin
            q_push = 1'b0;
          end
        end
        dle_pkg::KIND_RX_ACC: begin
          if (state_r == dle_pkg::LS_ESTABLISHING) begin
            q_push            = 1'b1;
            q_data.action     = dle_pkg::ACT_ACC_OK;
            q_data.peer_ip    = in_rx_peer_ip;
            peer_ip_nxt       = in_rx_peer_ip;
            timer_running_nxt = 1'b0;
            state_nxt         = dle_pkg::LS_ESTABLISHED;
          end
        end
        dle_pkg::KIND_RX_REJ: begin
          if (state_r == dle_pkg::LS_ESTABLISHING) begin
            q_push = 1'b1;
            if (cause_ok) begin
              q_data.action     = dle_pkg::ACT_REJ_OK;
              timer_running_nxt = 1'b0;
              state_nxt         = dle_pkg::LS_RELEASED;
            end else begin
              q_data.action = dle_pkg::ACT_ERROR;
            end
          end else if (state_r == dle_pkg::LS_ESTABLISHED) begin
            q_push        = 1'b1;
            q_data.action = dle_pkg::ACT_ERROR;
          end
        end
        dle_pkg::KIND_TICK: begin
          // A loaded count of zero or one expires on the next tick.
          if (timer_running_r) begin
            if (timer_count_r > 32'd1) begin
              timer_count_nxt = timer_count_r - 32'd1;
            end else begin
              timer_count_nxt = 32'd0;
              if ((state_r == dle_pkg::LS_ESTABLISHING) &&
                  (retry_count_r < cfg.rtx_max)) begin
                q_push          = 1'b1;
                q_data.action   = dle_pkg::ACT_RETX;
                retry_count_nxt = retry_count_r + 8'd1;
                timer_count_nxt = cfg.retx_ticks;
              end else begin
                timer_running_nxt = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Link state, timer and learned peer address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= dle_pkg::LS_INIT;
      timer_count_r   <= 32'd0;
      timer_running_r <= 1'b0;
      retry_count_r   <= 8'd0;
      peer_ip_r       <= 32'd0;
    end else begin
      state_r         <= state_nxt;
      timer_count_r   <= timer_count_nxt;
      timer_running_r <= timer_running_nxt;
      retry_count_r   <= retry_count_nxt;
      peer_ip_r       <= peer_ip_nxt;
    end
  end

endmodule

// ===== src/dle_queue.sv =====
// Short queue of record sequences between the front end and the back end.
module dle_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dle_pkg::qentry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output dle_pkg::qentry_t head_data
);

  dle_pkg::qentry_t                 mem_r [dle_pkg::QUEUE_DEPTH];
  logic [dle_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dle_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dle_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full       = (count_r == dle_pkg::QCNT_W'(dle_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/dle_back.sv =====
// Back end: expands each queued sequence into records for the output register, one per cycle unless stalled.
module dle_back (
  input  logic             clk,
  input  logic             rst_n,
  input  dle_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  dle_pkg::qentry_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output dle_pkg::rec_t    out_rec
);

  typedef enum logic [2:0] {
    OP_SEND_REQ,
    OP_SEND_ACC,
    OP_SEND_REJ,
    OP_NOTICE,
    OP_ERROR
  } op_t;

  op_t                  op;
  dle_pkg::link_state_t note_state;
  logic                 seq_last;
  dle_pkg::rec_t        rec;
  logic                 load;
  logic [1:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dle_pkg::rec_t        out_rec_r;

  // Which record of the sequence comes next.
  always_comb begin
    op         = OP_ERROR;
    note_state = dle_pkg::LS_INIT;
    seq_last   = 1'b1;
    unique case (q_data.action)
      dle_pkg::ACT_START: begin
        seq_last = (idx_r == 2'd1);
        if (idx_r == 2'd0) begin
          op = OP_SEND_REQ;
        end else begin
          op         = OP_NOTICE;
          note_state = dle_pkg::LS_ESTABLISHING;
        end
      end
      dle_pkg::ACT_REQ_ACCEPT: begin
        seq_last = (idx_r == 2'd2);
        if (idx_r == 2'd0) begin
          op         = OP_NOTICE;
          note_state = dle_pkg::LS_ESTABLISHING;
        end else if (idx_r == 2'd1) begin
          op = OP_SEND_ACC;
        end else begin
          op         = OP_NOTICE;
          note_state = dle_pkg::LS_ESTABLISHED;
        end
      end
      dle_pkg::ACT_REQ_REJECT: begin
        seq_last = (idx_r == 2'd2);
        if (idx_r == 2'd0) begin
          op         = OP_NOTICE;
          note_state = dle_pkg::LS_ESTABLISHING;
        end else if (idx_r == 2'd1) begin
          op = OP_SEND_REJ;
        end else begin
          op         = OP_NOTICE;
          note_state = dle_pkg::LS_RELEASED;
        end
      end
      dle_pkg::ACT_RESEND_ACC: op = OP_SEND_ACC;
      dle_pkg::ACT_ACC_OK: begin
        op         = OP_NOTICE;
        note_state = dle_pkg::LS_ESTABLISHED;
      end
      dle_pkg::ACT_REJ_OK: begin
        op         = OP_NOTICE;
        note_state = dle_pkg::LS_RELEASED;
      end
      dle_pkg::ACT_RETX:  op = OP_SEND_REQ;
      dle_pkg::ACT_ERROR: op = OP_ERROR;
      default:            op = OP_ERROR;
    endcase
  end

  // Record fields for the chosen record.
  always_comb begin
    rec      = '0;
    rec.last = seq_last;
    unique case (op)
      OP_SEND_REQ: begin
        rec.record_kind = dle_pkg::REC_SEND;
        rec.msg_type    = dle_pkg::MSG_REQ;
        rec.dest_l2_id  = cfg.peer_l2_id;
        rec.lc_id       = dle_pkg::LC_REQ;
        rec.src_l2_id   = cfg.self_l2_id;
        rec.ip_tag      = cfg.self_ip;
        if (cfg.is_relay_conn && cfg.is_initiating) begin
          rec.relay_code_out = cfg.relay_code;
        end
      end
      OP_SEND_ACC: begin
        rec.record_kind = dle_pkg::REC_SEND;
        rec.msg_type    = dle_pkg::MSG_ACC;
        rec.dest_l2_id  = cfg.peer_l2_id;
        rec.lc_id       = dle_pkg::LC_RSP;
        rec.src_l2_id   = cfg.self_l2_id;
        rec.ip_tag      = cfg.self_ip;
      end
      OP_SEND_REJ: begin
        rec.record_kind  = dle_pkg::REC_SEND;
        rec.msg_type     = dle_pkg::MSG_REJ;
        rec.dest_l2_id   = cfg.peer_l2_id;
        rec.lc_id        = dle_pkg::LC_RSP;
        rec.reject_cause = dle_pkg::CAUSE_RELAY_FAIL;
      end
      OP_NOTICE: begin
        rec.record_kind = dle_pkg::REC_NOTICE;
        rec.dest_l2_id  = cfg.peer_l2_id;
        rec.link_state  = note_state;
        if (note_state == dle_pkg::LS_ESTABLISHED) begin
          rec.peer_ip_out = q_data.peer_ip;
          if (cfg.is_relay_conn) begin
            rec.relay_code_out = cfg.relay_code;
            rec.relay_role     = cfg.is_initiating ? dle_pkg::ROLE_REMOTE
                                                   : dle_pkg::ROLE_RELAY;
          end
        end
      end
      OP_ERROR: begin
        rec.record_kind = dle_pkg::REC_ERROR;
        rec.link_state  = q_data.state;
      end
      default: begin
        rec.record_kind = dle_pkg::REC_ERROR;
      end
    endcase
  end

  // Output register handshake and record index.
  always_comb begin
    load    = q_valid && (!out_valid_r || !out_stall);
    q_pop   = load && seq_last;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = seq_last ? 2'd0 : idx_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r <= rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

endmodule

// ===== src/direct_link_establishment_fsm.sv =====
// Direct link establishment block for one sidelink unicast link: an event is accepted in
// every cycle while the four-entry queue between front end and back end has room, and the
// link state, timer and retry count are updated in the cycle of acceptance. Each event
// yields zero to three result records; the back end drives one record per cycle into the
// output register while the output is not stalled, one at a time from the single record
// builder. A record flagged last closes the records of one event. Configuration writes
// take effect the next cycle.
module direct_link_establishment_fsm (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Event input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [23:0] in_rx_relay_code,
  input  logic [31:0] in_rx_peer_ip,
  input  logic [7:0]  in_rx_cause,
  // Record output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [1:0]  out_msg_type,
  output logic [23:0] out_dest_l2_id,
  output logic [1:0]  out_lc_id,
  output logic [23:0] out_src_l2_id,
  output logic [23:0] out_relay_code_out,
  output logic [7:0]  out_reject_cause,
  output logic [31:0] out_ip_tag,
  output logic [2:0]  out_link_state,
  output logic [31:0] out_peer_ip_out,
  output logic [1:0]  out_relay_role,
  output logic        out_last
);

  dle_pkg::cfg_t    cfg_r, cfg_nxt;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  dle_pkg::qentry_t q_wdata;
  dle_pkg::qentry_t q_head;
  dle_pkg::rec_t    rec;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (dle_pkg::cfg_idx_t'(cfg_index))
        dle_pkg::CFG_SELF_L2_ID:    cfg_nxt.self_l2_id    = cfg_wdata[23:0];
        dle_pkg::CFG_PEER_L2_ID:    cfg_nxt.peer_l2_id    = cfg_wdata[23:0];
        dle_pkg::CFG_IS_INITIATING: cfg_nxt.is_initiating = cfg_wdata[0];
        dle_pkg::CFG_IS_RELAY_CONN: cfg_nxt.is_relay_conn = cfg_wdata[0];
        dle_pkg::CFG_RELAY_CODE:    cfg_nxt.relay_code    = cfg_wdata[23:0];
        dle_pkg::CFG_SELF_IP:       cfg_nxt.self_ip       = cfg_wdata;
        dle_pkg::CFG_RTX_MAX:       cfg_nxt.rtx_max       = cfg_wdata[7:0];
        dle_pkg::CFG_RETX_TICKS:    cfg_nxt.retx_ticks    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{self_l2_id: 24'd0, peer_l2_id: 24'd0, is_initiating: 1'b0,
                 is_relay_conn: 1'b0, relay_code: 24'd0, self_ip: 32'd0,
                 rtx_max: dle_pkg::RTX_MAX_RST, retx_ticks: dle_pkg::RETX_TICKS_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dle_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_relay_code (in_rx_relay_code),
    .in_rx_peer_ip    (in_rx_peer_ip),
    .in_rx_cause      (in_rx_cause),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  dle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  dle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (rec)
  );

  // Record fields onto the output ports.
  assign out_record_kind    = rec.record_kind;
  assign out_msg_type       = rec.msg_type;
  assign out_dest_l2_id     = rec.dest_l2_id;
  assign out_lc_id          = rec.lc_id;
  assign out_src_l2_id      = rec.src_l2_id;
  assign out_relay_code_out = rec.relay_code_out;
  assign out_reject_cause   = rec.reject_cause;
  assign out_ip_tag         = rec.ip_tag;
  assign out_link_state     = rec.link_state;
  assign out_peer_ip_out    = rec.peer_ip_out;
  assign out_relay_role     = rec.relay_role;
  assign out_last           = rec.last;

endmodule
